FILE: sv/ddays_pkg.sv
// ----------------------------------------------------------------------------
// ddays_pkg
// Shared widths, constants, status codes and calendar tables for the
// date difference pipeline.
// ----------------------------------------------------------------------------
package ddays_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MON_W   = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned TOTAL_W = 22;
	localparam int unsigned WY_W    = 14;
	localparam int unsigned REM_W   = 9;

	// serial day number and full difference width
	localparam int unsigned DN_W    = 23;
	// quotient by 365 before masking, and uncorrected remainder
	localparam int unsigned QUO_W   = 15;
	localparam int unsigned REMX_W  = 10;

	localparam int unsigned MAX_YEAR_DEF = 9999;
	localparam logic [YEAR_W-1:0] FIRST_YEAR = YEAR_W'(1582);

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EARLIER = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

	localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

	localparam int unsigned DAYS_PER_YEAR = 365;

	// floor(x / 25) = (x * RECIP_25) >> SHIFT_25 for x below 43690
	localparam int unsigned SHIFT_25 = 17;
	localparam int unsigned RECIP_25 = ((1 << SHIFT_25) + 24) / 25;

	// 25 * inverse == 1 modulo 2^12 and 2^10
	localparam int unsigned INV25_12 = 3113;
	localparam int unsigned INV25_10 = 41;
	localparam int unsigned MULT25_MAX_12 = 4095 / 25;
	localparam int unsigned MULT25_MAX_10 = 1023 / 25;

	// estimate of t / 365, low by at most one for t below 2^23
	localparam int unsigned SHIFT_365 = 23;
	localparam int unsigned RECIP_365 = (1 << SHIFT_365) / DAYS_PER_YEAR;

	typedef struct packed {
		logic            ok;
		logic [DN_W-1:0] dnum;
	} date_info_t;

	function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/ddays_date_unit.sv
// ----------------------------------------------------------------------------
// ddays_date_unit
// Two-stage date front end: quotients and leap flag, then field check and
// serial day number.
// ----------------------------------------------------------------------------
module ddays_date_unit #(
	parameter int unsigned MAX_YEAR = ddays_pkg::MAX_YEAR_DEF
) (
	input  logic                             clk,
	input  logic [ddays_pkg::DAY_W-1:0]      day,
	input  logic [ddays_pkg::MON_W-1:0]      month,
	input  logic [ddays_pkg::YEAR_W-1:0]     year,
	output ddays_pkg::date_info_t            info
);

	logic [ddays_pkg::YEAR_W-1:0] prev_y;
	logic [11:0] py4;
	logic [9:0]  py16;
	logic [24:0] m100;
	logic [22:0] m400;
	logic [11:0] yq4;
	logic [9:0]  yq16;
	logic [11:0] inv4;
	logic [9:0]  inv16;
	logic        div100;
	logic        div400;
	logic        leap;

	logic [ddays_pkg::DAY_W-1:0]  day_s2;
	logic [ddays_pkg::MON_W-1:0]  month_s2;
	logic [ddays_pkg::YEAR_W-1:0] year_s2;
	logic [ddays_pkg::YEAR_W-1:0] prev_s2;
	logic [11:0] q4_s2;
	logic [7:0]  q100_s2;
	logic [5:0]  q400_s2;
	logic        leap_s2;

	logic        ok;
	logic [ddays_pkg::DN_W-1:0] dnum;

	always_comb begin
		prev_y = year - ddays_pkg::YEAR_W'(1);
		py4    = prev_y[ddays_pkg::YEAR_W-1:2];
		py16   = prev_y[ddays_pkg::YEAR_W-1:4];
		m100   = 25'(py4) * 25'(ddays_pkg::RECIP_25);
		m400   = 23'(py16) * 23'(ddays_pkg::RECIP_25);
		yq4    = year[ddays_pkg::YEAR_W-1:2];
		yq16   = year[ddays_pkg::YEAR_W-1:4];
		inv4   = 12'(24'(yq4) * 24'(ddays_pkg::INV25_12));
		inv16  = 10'(20'(yq16) * 20'(ddays_pkg::INV25_10));
		div100 = (year[1:0] == 2'd0) && (32'(inv4) <= ddays_pkg::MULT25_MAX_12);
		div400 = (year[3:0] == 4'd0) && (32'(inv16) <= ddays_pkg::MULT25_MAX_10);
		leap   = ((year[1:0] == 2'd0) && !div100) || div400;
	end

	always_ff @(posedge clk) begin
		day_s2   <= day;
		month_s2 <= month;
		year_s2  <= year;
		prev_s2  <= prev_y;
		q4_s2    <= py4;
		q100_s2  <= 8'(m100 >> ddays_pkg::SHIFT_25);
		q400_s2  <= 6'(m400 >> ddays_pkg::SHIFT_25);
		leap_s2  <= leap;
	end

	always_comb begin
		ok = (year_s2 >= ddays_pkg::FIRST_YEAR)
			&& (32'(year_s2) <= MAX_YEAR)
			&& (month_s2 >= ddays_pkg::MONTH_JAN)
			&& (month_s2 <= ddays_pkg::MONTH_DEC)
			&& (day_s2 != '0)
			&& (day_s2 <= ddays_pkg::month_len(month_s2, leap_s2));
		dnum = ddays_pkg::DN_W'(prev_s2) * ddays_pkg::DN_W'(ddays_pkg::DAYS_PER_YEAR)
			+ ddays_pkg::DN_W'(q4_s2)
			- ddays_pkg::DN_W'(q100_s2)
			+ ddays_pkg::DN_W'(q400_s2)
			+ ddays_pkg::DN_W'(ddays_pkg::days_before(month_s2))
			+ ddays_pkg::DN_W'((month_s2 > ddays_pkg::MONTH_FEB) && leap_s2)
			+ ddays_pkg::DN_W'(day_s2);
	end

	always_ff @(posedge clk) begin
		info.ok   <= ok;
		info.dnum <= dnum;
	end

endmodule

FILE: sv/ddays_div365.sv
// ----------------------------------------------------------------------------
// ddays_div365
// Two-stage split of the day count into 365-day years and remaining days:
// reciprocal estimate, then one correction step.
// ----------------------------------------------------------------------------
module ddays_div365 (
	input  logic                             clk,
	input  logic [ddays_pkg::STAT_W-1:0]     status_in,
	input  logic [ddays_pkg::DN_W-1:0]       total_in,
	output logic [ddays_pkg::STAT_W-1:0]     status,
	output logic [ddays_pkg::TOTAL_W-1:0]    total_days,
	output logic [ddays_pkg::WY_W-1:0]       whole_years,
	output logic [ddays_pkg::REM_W-1:0]      remaining_days
);

	logic [37:0] prod;
	logic [ddays_pkg::QUO_W-1:0]  quo_s5;
	logic [ddays_pkg::DN_W-1:0]   total_s5;
	logic [ddays_pkg::STAT_W-1:0] status_s5;

	logic [ddays_pkg::DN_W-1:0]   back;
	logic [ddays_pkg::REMX_W-1:0] rem_raw;
	logic                         fix;
	logic [ddays_pkg::QUO_W-1:0]  quo;
	logic [ddays_pkg::REMX_W-1:0] rem;

	assign prod = 38'(total_in) * 38'(ddays_pkg::RECIP_365);

	always_ff @(posedge clk) begin
		quo_s5    <= ddays_pkg::QUO_W'(prod >> ddays_pkg::SHIFT_365);
		total_s5  <= total_in;
		status_s5 <= status_in;
	end

	always_comb begin
		back    = ddays_pkg::DN_W'(quo_s5) * ddays_pkg::DN_W'(ddays_pkg::DAYS_PER_YEAR);
		rem_raw = ddays_pkg::REMX_W'(total_s5 - back);
		fix     = 32'(rem_raw) >= ddays_pkg::DAYS_PER_YEAR;
		quo     = quo_s5 + ddays_pkg::QUO_W'(fix);
		rem     = fix ? rem_raw - ddays_pkg::REMX_W'(ddays_pkg::DAYS_PER_YEAR) : rem_raw;
	end

	always_ff @(posedge clk) begin
		status         <= status_s5;
		total_days     <= total_s5[ddays_pkg::TOTAL_W-1:0];
		whole_years    <= quo[ddays_pkg::WY_W-1:0];
		remaining_days <= rem[ddays_pkg::REM_W-1:0];
	end

endmodule

FILE: sv/date_difference_days.sv
// ----------------------------------------------------------------------------
// date_difference_days
// Days between two Gregorian dates, with field check and a split into
// 365-day years and remaining days.
// ----------------------------------------------------------------------------
// A date pair is taken on any cycle with start high; busy stays low, so one
// pair per clock is sustained. Each pair gives one result beat on done, in
// order; the depth comes from the input register, the two date stages, the
// compare stage and the two stages of the divide by 365. The receiver cannot
// stall, so results must be captured on the cycle that done is high.
// ----------------------------------------------------------------------------
module date_difference_days #(
	parameter int unsigned MAX_YEAR = ddays_pkg::MAX_YEAR_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ddays_pkg::DAY_W-1:0]      start_day,
	input  logic [ddays_pkg::MON_W-1:0]      start_month,
	input  logic [ddays_pkg::YEAR_W-1:0]     start_year,
	input  logic [ddays_pkg::DAY_W-1:0]      end_day,
	input  logic [ddays_pkg::MON_W-1:0]      end_month,
	input  logic [ddays_pkg::YEAR_W-1:0]     end_year,
	output logic                             done,
	output logic [ddays_pkg::STAT_W-1:0]     status,
	output logic [ddays_pkg::TOTAL_W-1:0]    total_days,
	output logic [ddays_pkg::WY_W-1:0]       whole_years,
	output logic [ddays_pkg::REM_W-1:0]      remaining_days
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [ddays_pkg::DAY_W-1:0]  sday_s1, eday_s1;
	logic [ddays_pkg::MON_W-1:0]  smon_s1, emon_s1;
	logic [ddays_pkg::YEAR_W-1:0] syear_s1, eyear_s1;

	ddays_pkg::date_info_t sinfo_s3, einfo_s3;

	logic [ddays_pkg::STAT_W-1:0] status_s4;
	logic [ddays_pkg::DN_W-1:0]   total_s4;

	assign busy = 1'b0;
	assign done = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		sday_s1  <= start_day;
		smon_s1  <= start_month;
		syear_s1 <= start_year;
		eday_s1  <= end_day;
		emon_s1  <= end_month;
		eyear_s1 <= end_year;
	end

	ddays_date_unit #(.MAX_YEAR(MAX_YEAR)) u_start_date (
		.clk   (clk),
		.day   (sday_s1),
		.month (smon_s1),
		.year  (syear_s1),
		.info  (sinfo_s3)
	);

	ddays_date_unit #(.MAX_YEAR(MAX_YEAR)) u_end_date (
		.clk   (clk),
		.day   (eday_s1),
		.month (emon_s1),
		.year  (eyear_s1),
		.info  (einfo_s3)
	);

	always_ff @(posedge clk) begin
		if (!(sinfo_s3.ok && einfo_s3.ok)) begin
			status_s4 <= ddays_pkg::STATUS_INVALID;
			total_s4  <= '0;
		end else if (einfo_s3.dnum < sinfo_s3.dnum) begin
			status_s4 <= ddays_pkg::STATUS_EARLIER;
			total_s4  <= '0;
		end else begin
			status_s4 <= ddays_pkg::STATUS_OK;
			total_s4  <= einfo_s3.dnum - sinfo_s3.dnum;
		end
	end

	ddays_div365 u_div365 (
		.clk            (clk),
		.status_in      (status_s4),
		.total_in       (total_s4),
		.status         (status),
		.total_days     (total_days),
		.whole_years    (whole_years),
		.remaining_days (remaining_days)
	);

	a_beat_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("result beat missing six cycles after accept");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ddays_pkg::STATUS_OK)
		|-> (total_days == '0 && whole_years == '0 && remaining_days == '0))
		else $error("nonzero counts on a rejected date pair");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(remaining_days) < ddays_pkg::DAYS_PER_YEAR))
		else $error("remaining days out of range");

	a_same_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && status_s4 != ddays_pkg::STATUS_OK) |-> (total_s4 == '0))
		else $error("rejected pair carries a day count");

endmodule
